// ===== rtl/rvqd_pkg.sv =====
// Shared types, constants and fp16/fp32 arithmetic functions of the weight decoder.
`default_nettype none
package rvqd_pkg;

    // Default sizes of the codebook store.
    localparam int ENTRIES_DEF    = 256;
    localparam int MAX_DIM_DEF    = 8;
    localparam int MAX_STAGES_DEF = 3;
    localparam int KINDS_DEF      = 3;

    // Number of stage slots carried through the datapath.
    localparam int STAGE_SLOTS = 3;

    // Floating-point bit patterns.
    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;

    // Configuration register indexes.
    localparam logic CFG_STAGE_COUNT   = 1'b0;
    localparam logic CFG_VECTOR_LENGTH = 1'b1;

    // Function codes of an input transaction.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // One classified command as it travels from the front end to the back end.
    typedef struct packed {
        logic        is_load;
        logic        wr_ok;
        logic [1:0]  kind;
        logic [1:0]  stage;
        logic [7:0]  entry;
        logic [2:0]  dim;
        logic [15:0] half;
        logic [7:0]  code0;
        logic [7:0]  code1;
        logic [7:0]  code2;
        logic [15:0] scale;
        logic        three;
        logic [3:0]  len;
    } cmd_t;

    // Widen fp16 bits to fp32 bits; fp16 subnormals become fp32 normals.
    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] p;
        logic [3:0] k;
        logic [9:0] mn;
        logic [7:0] ex;
        logic [31:0] r;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) p = 4'(i);
        end
        k  = 4'd10 - p;
        mn = m << k;
        ex = 8'd113 - {4'd0, k};
        if (e == 5'd0) begin
            if (m == 10'd0) r = {s, 31'd0};
            else            r = {s, ex, mn, 13'd0};
        end else if (e == 5'd31) begin
            r = {s, 8'hff, m, 13'd0};
        end else begin
            r = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

    // fp32 addition, round to nearest even. Operands are normal, zero, infinite or NaN.
    function automatic logic [31:0] fp32_add(logic [31:0] x, logic [31:0] y);
        logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
        logic        swap;
        logic [31:0] big, sml;
        logic [7:0]  d;
        logic [26:0] bm, sfull, ssh;
        logic        sticky;
        logic [27:0] sum;
        logic [26:0] norm;
        logic [4:0]  lz;
        logic [9:0]  ex;
        logic [24:0] rnd;
        logic [22:0] man;
        logic [31:0] r;
        x_nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
        y_nan  = (y[30:23] == 8'hff) && (y[22:0] != 23'd0);
        x_inf  = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
        y_inf  = (y[30:23] == 8'hff) && (y[22:0] == 23'd0);
        x_zero = (x[30:0] == 31'd0);
        y_zero = (y[30:0] == 31'd0);
        swap   = (y[30:0] > x[30:0]);
        big    = swap ? y : x;
        sml    = swap ? x : y;
        d      = big[30:23] - sml[30:23];
        bm     = {1'b1, big[22:0], 3'd0};
        sfull  = {1'b1, sml[22:0], 3'd0};
        if (d >= 8'd27) begin
            ssh    = 27'd0;
            sticky = 1'b1;
        end else begin
            ssh    = sfull >> d;
            sticky = |(sfull & ~({27{1'b1}} << d));
        end
        ssh[0] = ssh[0] | sticky;
        if (big[31] == sml[31]) sum = {1'b0, bm} + {1'b0, ssh};
        else                    sum = {1'b0, bm} - {1'b0, ssh};
        ex = {2'd0, big[30:23]};
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (sum[i]) lz = 5'(26 - i);
        end
        if (sum[27]) begin
            norm    = sum[27:1];
            norm[0] = sum[1] | sum[0];
            ex      = ex + 10'd1;
        end else begin
            norm = sum[26:0] << lz;
            ex   = ex - {5'd0, lz};
        end
        rnd = {1'b0, norm[26:3]} + {24'd0, norm[2] & (norm[1] | norm[0] | norm[3])};
        if (rnd[24]) begin
            ex  = ex + 10'd1;
            man = rnd[23:1];
        end else begin
            man = rnd[22:0];
        end
        // Special operands first, then the exact cancellation case.
        if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) r = QNAN_BITS;
        else if (x_inf)                 r = x;
        else if (y_inf)                 r = y;
        else if (x_zero && y_zero)      r = {x[31] & y[31], 31'd0};
        else if (x_zero)                r = y;
        else if (y_zero)                r = x;
        else if (sum == 28'd0)          r = 32'd0;
        else                            r = {big[31], ex[7:0], man};
        return r;
    endfunction

    // fp32 multiply, round to nearest even; NaN results are canonical.
    function automatic logic [31:0] fp32_mul(logic [31:0] x, logic [31:0] y);
        logic        s;
        logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
        logic [47:0] p;
        logic [9:0]  ex;
        logic [22:0] man;
        logic        g, st;
        logic [23:0] rnd;
        logic [31:0] r;
        s      = x[31] ^ y[31];
        x_nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
        y_nan  = (y[30:23] == 8'hff) && (y[22:0] != 23'd0);
        x_inf  = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
        y_inf  = (y[30:23] == 8'hff) && (y[22:0] == 23'd0);
        x_zero = (x[30:23] == 8'd0);
        y_zero = (y[30:23] == 8'd0);
        p      = {1'b1, x[22:0]} * {1'b1, y[22:0]};
        ex     = {2'd0, x[30:23]} + {2'd0, y[30:23]} - 10'd127;
        if (p[47]) begin
            man = p[46:24];
            g   = p[23];
            st  = |p[22:0];
            ex  = ex + 10'd1;
        end else begin
            man = p[45:23];
            g   = p[22];
            st  = |p[21:0];
        end
        rnd = {1'b0, man} + {23'd0, g & (st | man[0])};
        if (rnd[23]) begin
            ex  = ex + 10'd1;
            man = 23'd0;
        end else begin
            man = rnd[22:0];
        end
        if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero)) r = QNAN_BITS;
        else if (x_inf || y_inf)   r = {s, 8'hff, 23'd0};
        else if (x_zero || y_zero) r = {s, 31'd0};
        else                       r = {s, ex[7:0], man};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/residual_vq_weight_decoder_unit.sv =====
// Top level of the residual vector-quantized weight decoder.
// Path: a decode element passes from the queue head through the bank read, first add, second
// add and multiply registers to the result port; the whole pipeline stalls while it is not taken.
// Throughput: one element per cycle through the banked codebook read while the result port does
// not stall; a decode yields its clamped vector_length elements and a load yields none.
// Reset: synchronous active-low aresetn clears control state and sets stage_count to 3 and
// vector_length to 8; the codebook banks are not cleared and hold garbage until written.
`default_nettype none
module residual_vq_weight_decoder_unit import rvqd_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF,
    parameter int KINDS      = KINDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [1:0]  s_book_kind,
    input  wire logic [1:0]  s_load_stage,
    input  wire logic [7:0]  s_load_entry,
    input  wire logic [2:0]  s_load_dim,
    input  wire logic [15:0] s_half_word,
    input  wire logic [7:0]  s_code_first,
    input  wire logic [7:0]  s_code_second,
    input  wire logic [7:0]  s_code_third,
    input  wire logic [15:0] s_row_scale,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_weight_bits,
    output logic [2:0]       m_element_index,
    output logic             m_last
);

    logic [1:0] stage_count_reg, stage_count_next;
    logic [3:0] vector_length_reg, vector_length_next;
    logic       push_valid, push_ready;
    cmd_t       push_cmd;
    logic       q_valid, q_pop;
    cmd_t       q_cmd;

    // Configuration register writes.
    always_comb begin
        stage_count_next   = stage_count_reg;
        vector_length_next = vector_length_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_STAGE_COUNT:   stage_count_next   = cfg_wdata[1:0];
                CFG_VECTOR_LENGTH: vector_length_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg   <= 2'd3;
            vector_length_reg <= 4'd8;
        end else begin
            stage_count_reg   <= stage_count_next;
            vector_length_reg <= vector_length_next;
        end
    end

    rvqd_front #(
        .ENTRIES(ENTRIES), .MAX_DIM(MAX_DIM), .MAX_STAGES(MAX_STAGES), .KINDS(KINDS)
    ) u_front (
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_book_kind(s_book_kind),
        .s_load_stage(s_load_stage), .s_load_entry(s_load_entry), .s_load_dim(s_load_dim),
        .s_half_word(s_half_word), .s_code_first(s_code_first),
        .s_code_second(s_code_second), .s_code_third(s_code_third),
        .s_row_scale(s_row_scale), .stage_count(stage_count_reg),
        .vector_length(vector_length_reg), .push_valid(push_valid),
        .push_ready(push_ready), .push_cmd(push_cmd)
    );

    rvqd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(push_valid), .in_ready(push_ready), .in_cmd(push_cmd),
        .out_valid(q_valid), .out_ready(q_pop), .out_cmd(q_cmd)
    );

    rvqd_back #(
        .ENTRIES(ENTRIES), .MAX_DIM(MAX_DIM), .MAX_STAGES(MAX_STAGES), .KINDS(KINDS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_weight_bits(m_weight_bits),
        .m_element_index(m_element_index), .m_last(m_last)
    );

    // A NaN result always leaves in canonical quiet form.
    a_nan_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_weight_bits[30:23] == 8'hff && m_weight_bits[22:0] != 23'd0)
        |-> m_weight_bits == QNAN_BITS)
        else $error("non-canonical NaN on result channel");

    // After a non-final element, the next visible element is its successor.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last)
        |=> (!m_valid || m_element_index == 3'($past(m_element_index) + 3'd1)))
        else $error("element index skipped within a vector");

    // After the final element, the next visible element opens a new vector.
    a_index_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (!m_valid || m_element_index == 3'd0))
        else $error("vector did not restart at element zero");

    // The queue pops only a command that is present.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== rtl/rvqd_front.sv =====
// Front end: classifies input transactions into commands, clamping decode fields and flagging bad loads.
`default_nettype none
module rvqd_front import rvqd_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF,
    parameter int KINDS      = KINDS_DEF
) (
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [1:0]  s_book_kind,
    input  wire logic [1:0]  s_load_stage,
    input  wire logic [7:0]  s_load_entry,
    input  wire logic [2:0]  s_load_dim,
    input  wire logic [15:0] s_half_word,
    input  wire logic [7:0]  s_code_first,
    input  wire logic [7:0]  s_code_second,
    input  wire logic [7:0]  s_code_third,
    input  wire logic [15:0] s_row_scale,
    input  wire logic [1:0]  stage_count,
    input  wire logic [3:0]  vector_length,
    output logic             push_valid,
    input  wire logic        push_ready,
    output cmd_t             push_cmd
);

    function automatic logic [7:0] clamp_code(logic [7:0] c);
        return (int'(c) >= ENTRIES) ? 8'(ENTRIES - 1) : c;
    endfunction

    // Handshake passes straight to the queue.
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // Classify the transaction, flag a load with out-of-range fields, and clamp the decode codes, kind and length.
    always_comb begin
        push_cmd         = '0;
        push_cmd.is_load = (s_func == FUNC_LOAD);
        push_cmd.wr_ok   = (int'(s_book_kind) < KINDS) && (int'(s_load_stage) < MAX_STAGES) &&
                           (int'(s_load_entry) < ENTRIES) && (int'(s_load_dim) < MAX_DIM);
        push_cmd.stage   = s_load_stage;
        push_cmd.entry   = s_load_entry;
        push_cmd.dim     = s_load_dim;
        push_cmd.half    = s_half_word;
        push_cmd.scale   = s_row_scale;
        push_cmd.code0   = s_code_first;
        push_cmd.code1   = s_code_second;
        push_cmd.code2   = s_code_third;
        push_cmd.kind    = s_book_kind;
        if (s_func == FUNC_DECODE) begin
            push_cmd.code0 = clamp_code(s_code_first);
            push_cmd.code1 = clamp_code(s_code_second);
            push_cmd.code2 = clamp_code(s_code_third);
            if (int'(s_book_kind) >= KINDS) push_cmd.kind = 2'(KINDS - 1);
        end
        push_cmd.three = (int'(stage_count) >= 3) && (MAX_STAGES >= 3);
        if (vector_length == 4'd0)             push_cmd.len = 4'd1;
        else if (int'(vector_length) > MAX_DIM) push_cmd.len = 4'(MAX_DIM);
        else                                    push_cmd.len = vector_length;
    end

endmodule
`default_nettype wire

// ===== rtl/rvqd_queue.sv =====
// Two-entry command queue between the front end and the back end.
`default_nettype none
module rvqd_queue import rvqd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/rvqd_back.sv =====
// Back end: codebook banks, element sequencer and the add/add/multiply pipeline.
`default_nettype none
module rvqd_back import rvqd_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF,
    parameter int KINDS      = KINDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire cmd_t        q_cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_weight_bits,
    output logic [2:0]       m_element_index,
    output logic             m_last
);

    localparam int BANK_DEPTH = KINDS * ENTRIES * MAX_DIM;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);

    logic              adv;
    logic              el_last;
    logic [3:0]        dim_cnt_reg, dim_cnt_next;
    logic [ADDR_W-1:0] wr_addr;
    logic [16*STAGE_SLOTS-1:0] rd_bus;
    logic [7:0]        code_sel [STAGE_SLOTS];

    // Pipeline registers, stage 1 (after the bank read) to the output.
    logic        v1_reg, v2_reg, v3_reg, mv_reg;
    logic [2:0]  dim1_reg, dim2_reg, dim3_reg, dimo_reg;
    logic        last1_reg, last2_reg, last3_reg, lasto_reg;
    logic        three1_reg, three2_reg;
    logic [15:0] scale1_reg;
    logic [31:0] scale2_reg, scale3_reg;
    logic [31:0] sum2_reg, third2_reg, sum3_reg, wout_reg;
    logic [31:0] first_w;

    // The whole pipeline moves when the output register is free or being taken.
    assign adv     = !mv_reg || m_ready;
    assign el_last = ({1'b0, dim_cnt_reg} + 5'd1) == {1'b0, q_cmd.len};
    assign q_pop   = adv && q_valid && (q_cmd.is_load || el_last);

    // Element counter walks the dimensions of the decode at the queue head.
    always_comb begin
        dim_cnt_next = dim_cnt_reg;
        if (adv && q_valid && !q_cmd.is_load) dim_cnt_next = el_last ? 4'd0 : dim_cnt_reg + 4'd1;
    end

    assign wr_addr = ADDR_W'((int'(q_cmd.kind) * ENTRIES + int'(q_cmd.entry)) * MAX_DIM +
                             int'(q_cmd.dim));
    assign code_sel[0] = q_cmd.code0;
    assign code_sel[1] = q_cmd.code1;
    assign code_sel[2] = q_cmd.code2;

    // One codebook bank per stage, so all stages of an element are read in the same cycle.
    for (genvar st = 0; st < STAGE_SLOTS; st++) begin : g_bank
        if (st < MAX_STAGES) begin : g_mem
            logic [15:0]       mem [BANK_DEPTH];
            logic [15:0]       rd_reg;
            logic [ADDR_W-1:0] rd_addr;
            logic              wr_en;
            assign rd_addr = ADDR_W'((int'(q_cmd.kind) * ENTRIES + int'(code_sel[st])) *
                                     MAX_DIM + int'(dim_cnt_reg));
            assign wr_en   = adv && q_valid && q_cmd.is_load && q_cmd.wr_ok &&
                             (int'(q_cmd.stage) == st);
            always_ff @(posedge aclk) begin
                if (wr_en) mem[wr_addr] <= q_cmd.half;
                if (adv) rd_reg <= mem[rd_addr];
            end
            assign rd_bus[st*16 +: 16] = rd_reg;
        end else begin : g_none
            assign rd_bus[st*16 +: 16] = 16'd0;
        end
    end

    // Starting from +0.0 turns a negative zero first term into a positive zero.
    always_comb begin
        first_w = half_to_single(rd_bus[15:0]);
        if (first_w == 32'h8000_0000) first_w = 32'd0;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_cnt_reg <= 4'd0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            dim_cnt_reg <= dim_cnt_next;
            if (adv) begin
                v1_reg <= q_valid && !q_cmd.is_load;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                mv_reg <= v3_reg;
            end
        end
    end

    // Datapath registers: first add, second add, multiply.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dim1_reg   <= dim_cnt_reg[2:0];
            last1_reg  <= el_last;
            three1_reg <= q_cmd.three;
            scale1_reg <= q_cmd.scale;

            sum2_reg   <= fp32_add(first_w, half_to_single(rd_bus[31:16]));
            third2_reg <= half_to_single(rd_bus[47:32]);
            scale2_reg <= half_to_single(scale1_reg);
            three2_reg <= three1_reg;
            dim2_reg   <= dim1_reg;
            last2_reg  <= last1_reg;

            sum3_reg   <= three2_reg ? fp32_add(sum2_reg, third2_reg) : sum2_reg;
            scale3_reg <= scale2_reg;
            dim3_reg   <= dim2_reg;
            last3_reg  <= last2_reg;

            wout_reg   <= fp32_mul(sum3_reg, scale3_reg);
            dimo_reg   <= dim3_reg;
            lasto_reg  <= last3_reg;
        end
    end

    assign m_valid         = mv_reg;
    assign m_weight_bits   = wout_reg;
    assign m_element_index = dimo_reg;
    assign m_last          = lasto_reg;

endmodule
`default_nettype wire
